// File: sv/sliding_window_feature_normalizer_macros.svh
// assertion macros for the sliding window normaliser
// clk and rst_n must be visible where these are used
`ifndef SLIDING_WINDOW_FEATURE_NORMALIZER_MACROS_SVH
`define SLIDING_WINDOW_FEATURE_NORMALIZER_MACROS_SVH

// consequent checked in the same cycle
`define SWFN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SWFN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/swfn_pkg.sv
// ----------------------------------------------------------------------------
// swfn_pkg
// shared widths, register indexes, item types and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package swfn_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_FEATURES  = 64;
    localparam int WINDOW_DEPTH  = 256;
    localparam int POS_BITS      = 6;
    localparam int OUT_BITS      = 16;

    localparam int FC_BITS       = 7;
    localparam int LC_BITS       = 8;
    localparam int MSD_BITS      = 15;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [CFG_IDX_BITS-1:0] REG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_CONTEXT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_STDDEV    = 2'd2;

    // q3.12 output: x4096 against the real deviation, x16 against unit deviation
    localparam int DEV_SHIFT  = 12;
    localparam int UNIT_SHIFT = 4;
    // quotient bits worked out before saturation takes over
    localparam int QUOT_BITS  = 17;
    localparam int OUT_POS_MAX = 32767;
    localparam int OUT_NEG_MAG = 32768;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          stream_start;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] normalized_value;
        logic [POS_BITS-1:0]        feature_position;
        logic                       frame_last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_RING,
        ST_NCALC,
        ST_MUL,
        ST_VAR,
        ST_SQRT,
        ST_SEL,
        ST_RD,
        ST_PROD,
        ST_DIFF,
        ST_DIV,
        ST_EMIT,
        ST_DROP
    } state_t;

endpackage

`default_nettype wire

// File: sv/sliding_window_feature_normalizer.sv
// frame end: after its last item come the statistics, then for each result: read,
//   product, difference, 17 divide steps, emit (held while the output is full)
// throughput: one item per cycle while a frame fills; no item is taken while a frame
//   end is worked on (bit-serial products, 2-bit root, 1-bit divider)
// reset: asynchronous active low; window, accumulators and config cleared,
//   feature_count = 1; frame store and ring contents undefined until written
// ----------------------------------------------------------------------------
// sliding_window_feature_normalizer
// causal sliding-window mean / deviation normaliser with digit-serial arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_feature_normalizer_macros.svh"

module sliding_window_feature_normalizer #(
    parameter int MAX_FEATURES = swfn_pkg::MAX_FEATURES,
    parameter int WINDOW_DEPTH = swfn_pkg::WINDOW_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // item input
    input  wire logic                               in_valid,
    output      logic                               in_ready,
    input  wire swfn_pkg::in_item_t                 in_data,
    // result output
    output      logic                               out_valid,
    input  wire logic                               out_ready,
    output      swfn_pkg::out_item_t                out_data,
    // configuration writes
    input  wire logic                               cfg_we,
    input  wire logic [swfn_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [swfn_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // derived widths
    // ------------------------------------------------------------------
    localparam int SB    = swfn_pkg::SAMPLE_BITS;
    localparam int QB    = swfn_pkg::QUOT_BITS;
    localparam int CB    = $clog2(MAX_FEATURES);
    localparam int IDXW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FLW   = $clog2(MAX_FEATURES + 1);
    localparam int FSUMW = SB + CB;               // signed per-frame sum
    localparam int FSQW  = 2 * SB - 1 + CB;       // per-frame sum of squares
    localparam int WB    = $clog2(WINDOW_DEPTH);  // ring address
    localparam int FILLW = $clog2(WINDOW_DEPTH + 1);
    localparam int WSUMW = FSUMW + WB;
    localparam int WSQW  = FSQW + WB;
    localparam int NW    = $clog2(WINDOW_DEPTH * MAX_FEATURES + 1);
    localparam int P1W   = NW + WSQW;
    localparam int P2W   = 2 * WSUMW;
    localparam int PMAXW = (P1W > P2W) ? P1W : P2W;
    localparam int PW    = PMAXW + (PMAXW % 2);   // even, for 2-bit root steps
    localparam int RTW   = PW / 2;
    localparam int MULN  = (NW > WSUMW) ? NW : WSUMW;
    localparam int MDW   = swfn_pkg::MSD_BITS + NW;
    localparam int CW    = (RTW > MDW) ? RTW : MDW;
    localparam int DENW  = (RTW > NW) ? RTW : NW;
    localparam int DW    = NW + SB + 1;           // n*x - S
    localparam int AW    = ((DW + 14) > (DENW + QB + 2)) ? (DW + 14) : (DENW + QB + 2);
    localparam int L1    = (MULN > RTW) ? MULN : RTW;
    localparam int LOOPN = (L1 > QB) ? L1 : QB;
    localparam int CNTW  = $clog2(LOOPN + 1);
    localparam int REMW  = RTW + 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [swfn_pkg::FC_BITS-1:0]  fc_reg;
    logic [swfn_pkg::LC_BITS-1:0]  lc_reg;
    logic [swfn_pkg::MSD_BITS-1:0] msd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= swfn_pkg::FC_BITS'(1);
            lc_reg  <= '0;
            msd_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swfn_pkg::REG_FEATURE_COUNT: fc_reg  <= cfg_data[swfn_pkg::FC_BITS-1:0];
                swfn_pkg::REG_LEFT_CONTEXT:  lc_reg  <= cfg_data[swfn_pkg::LC_BITS-1:0];
                swfn_pkg::REG_MIN_STDDEV:    msd_reg <= cfg_data[swfn_pkg::MSD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state and control
    // ------------------------------------------------------------------
    swfn_pkg::state_t state_reg, state_next;

    logic [IDXW-1:0]         idx_reg;
    logic [FLW-1:0]          flen_reg;      // frame length seen at frame end
    logic [FLW-1:0]          count_reg;     // items buffered in the frame
    logic signed [FSUMW-1:0] fsum_acc_reg;
    logic [FSQW-1:0]         fsq_acc_reg;
    logic signed [WSUMW-1:0] wsum_reg;
    logic [WSQW-1:0]         wsq_reg;
    logic [WB-1:0]           head_reg;
    logic [FILLW-1:0]        fill_reg;
    logic [IDXW-1:0]         k_reg;
    logic [CNTW-1:0]         cnt_reg;
    logic                    out_valid_reg;
    swfn_pkg::out_item_t     out_reg;

    // datapath registers (no reset)
    logic [NW-1:0]           n_reg;
    logic [NW-1:0]           m1_reg;
    logic [WSUMW-1:0]        m2_reg;
    logic [PW-1:0]           a1_reg;
    logic [PW-1:0]           a2_reg;
    logic [PW-1:0]           nq_reg;
    logic [PW-1:0]           s2_reg;
    logic [MDW-1:0]          md_n_reg;
    logic [PW-1:0]           v_reg;
    logic [REMW-1:0]         rem_reg;
    logic [RTW-1:0]          root_reg;
    logic [DENW-1:0]         den_reg;
    logic                    use_dev_reg;
    logic signed [SB-1:0]    fs_rd_reg;
    logic signed [DW-1:0]    prod_reg;
    logic [AW-1:0]           a_reg;
    logic [AW-1:0]           d_reg;
    logic [QB-1:0]           q_reg;
    logic                    neg_reg;
    logic                    sat_reg;
    logic [FSUMW-1:0]        ring_sum_rd_reg;
    logic [FSQW-1:0]         ring_sq_rd_reg;

    // memories
    logic [SB-1:0]    frame_store [MAX_FEATURES];
    logic [FSUMW-1:0] ring_sum    [WINDOW_DEPTH];
    logic [FSQW-1:0]  ring_sq     [WINDOW_DEPTH];

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [FLW-1:0]          flen_cur;
    logic                    in_take;
    logic                    start;
    logic [IDXW-1:0]         idx_eff;
    logic                    in_last;
    logic signed [SB-1:0]    x_in;
    logic signed [2*SB-1:0]  x_sq_s;
    logic [2*SB-1:0]         x_sq;
    logic [WB:0]             slot_sum;
    logic [WB-1:0]           slot;
    logic [NW-1:0]           n_next;
    logic [WSUMW-1:0]        smag;
    logic [REMW+1:0]         rem_t;
    logic [REMW+1:0]         trial;
    logic signed [DW-1:0]    diff;
    logic [DW-1:0]           dmag;
    logic [AW-1:0]           a_sh;
    logic [AW-1:0]           a_full;
    logic [AW-1:0]           d_full;
    logic                    k_last;
    logic                    emit_load;
    logic                    drop_old;
    logic [swfn_pkg::OUT_BITS-1:0] res;

    // frame length clamped to 1..MAX_FEATURES, zero acts as one
    always_comb
    begin
        if (fc_reg == '0)
            flen_cur = FLW'(1);
        else if (32'(fc_reg) > 32'(MAX_FEATURES))
            flen_cur = FLW'(MAX_FEATURES);
        else
            flen_cur = FLW'(fc_reg);
    end

    assign x_in    = in_data.sample_value;
    assign start   = in_data.stream_start;
    assign idx_eff = start ? '0 : idx_reg;
    assign in_last = (32'(idx_eff) + 32'd1) >= 32'(flen_cur);
    assign x_sq_s  = x_in * x_in;
    assign x_sq    = $unsigned(x_sq_s);

    // ring slot just past the newest frame, wrapped at the ring depth
    always_comb
    begin
        slot_sum = (WB + 1)'(head_reg) + (WB + 1)'(fill_reg);
        if (32'(slot_sum) >= 32'(WINDOW_DEPTH))
            slot = WB'(32'(slot_sum) - 32'(WINDOW_DEPTH));
        else
            slot = WB'(slot_sum);
    end

    assign n_next = NW'(fill_reg) * NW'(flen_reg);
    assign smag   = wsum_reg[WSUMW-1] ? WSUMW'(-wsum_reg) : WSUMW'(wsum_reg);

    // one 2-bit step of the restoring square root
    assign rem_t = {rem_reg, v_reg[PW-1:PW-2]};
    assign trial = (REMW + 2)'({root_reg, 2'b01});

    // numerator and divisor of the rounded divide: (2|num| + d) / 2d
    always_comb
    begin
        diff   = prod_reg - DW'(wsum_reg);
        dmag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
        a_sh   = use_dev_reg ? (AW'(dmag) << swfn_pkg::DEV_SHIFT)
                             : (AW'(dmag) << swfn_pkg::UNIT_SHIFT);
        a_full = (a_sh << 1) + AW'(den_reg);
        d_full = AW'(den_reg) << 1;
    end

    assign k_last   = (32'(k_reg) + 32'd1) == 32'(count_reg);
    assign drop_old = (32'(fill_reg) > 32'(lc_reg)) ||
                      (32'(fill_reg) > 32'(WINDOW_DEPTH - 1));

    // saturate the quotient into q3.12
    always_comb
    begin
        if (neg_reg)
        begin
            if (sat_reg || (32'(q_reg) > 32'(swfn_pkg::OUT_NEG_MAG)))
                res = swfn_pkg::OUT_BITS'(-32'(swfn_pkg::OUT_NEG_MAG));
            else
                res = swfn_pkg::OUT_BITS'(-32'(q_reg));
        end
        else
        begin
            if (sat_reg || (32'(q_reg) > 32'(swfn_pkg::OUT_POS_MAX)))
                res = swfn_pkg::OUT_BITS'(swfn_pkg::OUT_POS_MAX);
            else
                res = swfn_pkg::OUT_BITS'(q_reg);
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swfn_pkg::ST_ACC:
                if (in_valid && in_last)
                    state_next = swfn_pkg::ST_RING;
            swfn_pkg::ST_RING:  state_next = swfn_pkg::ST_NCALC;
            swfn_pkg::ST_NCALC: state_next = swfn_pkg::ST_MUL;
            swfn_pkg::ST_MUL:
                if (32'(cnt_reg) == MULN - 1)
                    state_next = swfn_pkg::ST_VAR;
            swfn_pkg::ST_VAR:   state_next = swfn_pkg::ST_SQRT;
            swfn_pkg::ST_SQRT:
                if (32'(cnt_reg) == RTW - 1)
                    state_next = swfn_pkg::ST_SEL;
            swfn_pkg::ST_SEL:   state_next = swfn_pkg::ST_RD;
            swfn_pkg::ST_RD:    state_next = swfn_pkg::ST_PROD;
            swfn_pkg::ST_PROD:  state_next = swfn_pkg::ST_DIFF;
            swfn_pkg::ST_DIFF:  state_next = swfn_pkg::ST_DIV;
            swfn_pkg::ST_DIV:
                if (32'(cnt_reg) == QB - 1)
                    state_next = swfn_pkg::ST_EMIT;
            swfn_pkg::ST_EMIT:
                if (emit_load)
                    state_next = k_last ? swfn_pkg::ST_DROP : swfn_pkg::ST_RD;
            swfn_pkg::ST_DROP:  state_next = swfn_pkg::ST_ACC;
            default:            state_next = swfn_pkg::ST_ACC;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready  = (state_reg == swfn_pkg::ST_ACC);
        in_take   = in_ready && in_valid;
        // result register frees up in the same cycle it is taken
        emit_load = (state_reg == swfn_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swfn_pkg::ST_ACC;
            idx_reg       <= '0;
            flen_reg      <= FLW'(1);
            count_reg     <= FLW'(1);
            fsum_acc_reg  <= '0;
            fsq_acc_reg   <= '0;
            wsum_reg      <= '0;
            wsq_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                swfn_pkg::ST_ACC:
                begin
                    if (in_take)
                    begin
                        // stream start wipes the window before this item counts
                        if (start)
                        begin
                            wsum_reg <= '0;
                            wsq_reg  <= '0;
                            head_reg <= '0;
                            fill_reg <= '0;
                        end
                        fsum_acc_reg <= (start ? '0 : fsum_acc_reg) + FSUMW'(x_in);
                        fsq_acc_reg  <= (start ? '0 : fsq_acc_reg) + FSQW'(x_sq);
                        if (in_last)
                        begin
                            idx_reg   <= '0;
                            flen_reg  <= flen_cur;
                            count_reg <= FLW'(32'(idx_eff) + 32'd1);
                        end
                        else
                            idx_reg <= idx_eff + 1'b1;
                    end
                end
                swfn_pkg::ST_RING:
                begin
                    wsum_reg     <= wsum_reg + WSUMW'(fsum_acc_reg);
                    wsq_reg      <= wsq_reg + WSQW'(fsq_acc_reg);
                    fill_reg     <= fill_reg + 1'b1;
                    fsum_acc_reg <= '0;
                    fsq_acc_reg  <= '0;
                end
                swfn_pkg::ST_NCALC: cnt_reg <= '0;
                swfn_pkg::ST_MUL:   cnt_reg <= cnt_reg + 1'b1;
                swfn_pkg::ST_VAR:   cnt_reg <= '0;
                swfn_pkg::ST_SQRT:  cnt_reg <= cnt_reg + 1'b1;
                swfn_pkg::ST_SEL:   k_reg <= '0;
                swfn_pkg::ST_RD:    ;
                swfn_pkg::ST_PROD:  ;
                swfn_pkg::ST_DIFF:  cnt_reg <= '0;
                swfn_pkg::ST_DIV:   cnt_reg <= cnt_reg + 1'b1;
                swfn_pkg::ST_EMIT:
                    if (emit_load && !k_last)
                        k_reg <= k_reg + 1'b1;
                swfn_pkg::ST_DROP:
                begin
                    // oldest frame leaves once the window is over its context or fills the ring
                    if (drop_old)
                    begin
                        wsum_reg <= wsum_reg - WSUMW'($signed(ring_sum_rd_reg));
                        wsq_reg  <= wsq_reg - WSQW'(ring_sq_rd_reg);
                        head_reg <= (32'(head_reg) == WINDOW_DEPTH - 1) ? '0
                                                                        : head_reg + 1'b1;
                        fill_reg <= fill_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // memories: frame buffer and per-frame ring
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
            frame_store[idx_eff] <= x_in;
        fs_rd_reg <= frame_store[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == swfn_pkg::ST_RING)
        begin
            ring_sum[slot] <= fsum_acc_reg;
            ring_sq[slot]  <= fsq_acc_reg;
        end
        // oldest entry always on the read port
        ring_sum_rd_reg <= ring_sum[head_reg];
        ring_sq_rd_reg  <= ring_sq[head_reg];
    end

    // ------------------------------------------------------------------
    // digit-serial datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            swfn_pkg::ST_NCALC:
            begin
                // load both shift-add products: n*Q and |S|*|S|
                n_reg  <= n_next;
                m1_reg <= n_next;
                a1_reg <= PW'(wsq_reg);
                m2_reg <= smag;
                a2_reg <= PW'(smag);
                nq_reg <= '0;
                s2_reg <= '0;
            end
            swfn_pkg::ST_MUL:
            begin
                if (m1_reg[0])
                    nq_reg <= nq_reg + a1_reg;
                if (m2_reg[0])
                    s2_reg <= s2_reg + a2_reg;
                a1_reg   <= a1_reg << 1;
                a2_reg   <= a2_reg << 1;
                m1_reg   <= m1_reg >> 1;
                m2_reg   <= m2_reg >> 1;
                md_n_reg <= MDW'(msd_reg) * MDW'(n_reg);
            end
            swfn_pkg::ST_VAR:
            begin
                // variance numerator clamped at zero
                v_reg    <= (nq_reg >= s2_reg) ? (nq_reg - s2_reg) : '0;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            swfn_pkg::ST_SQRT:
            begin
                if (rem_t >= trial)
                begin
                    rem_reg  <= REMW'(rem_t - trial);
                    root_reg <= {root_reg[RTW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= REMW'(rem_t);
                    root_reg <= {root_reg[RTW-2:0], 1'b0};
                end
                v_reg <= v_reg << 2;
            end
            swfn_pkg::ST_SEL:
            begin
                // deviation at or below the floor divides by n (unit deviation)
                use_dev_reg <= CW'(root_reg) > CW'(md_n_reg);
                den_reg     <= (CW'(root_reg) > CW'(md_n_reg)) ? DENW'(root_reg)
                                                               : DENW'(n_reg);
            end
            swfn_pkg::ST_PROD:
                prod_reg <= DW'($signed({1'b0, n_reg})) * DW'(fs_rd_reg);
            swfn_pkg::ST_DIFF:
            begin
                neg_reg <= diff[DW-1];
                sat_reg <= a_full >= (d_full << QB);
                a_reg   <= a_full;
                d_reg   <= d_full << (QB - 1);
                q_reg   <= '0;
            end
            swfn_pkg::ST_DIV:
            begin
                if (a_reg >= d_reg)
                begin
                    a_reg <= a_reg - d_reg;
                    q_reg <= {q_reg[QB-2:0], 1'b1};
                end
                else
                    q_reg <= {q_reg[QB-2:0], 1'b0};
                d_reg <= d_reg >> 1;
            end
            swfn_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_reg.normalized_value <= $signed(res);
                    out_reg.feature_position <= swfn_pkg::POS_BITS'(k_reg);
                    out_reg.frame_last       <= k_last;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SWFN_ASSERT_SAME(a_fill_bound, state_reg == swfn_pkg::ST_ACC,
                      32'(fill_reg) < 32'(WINDOW_DEPTH), "window fill beyond ring depth")
    `SWFN_ASSERT_NEXT(a_emit_loads, emit_load, out_valid_reg, "result lost at emit")
    `SWFN_ASSERT_SAME(a_div_den, state_reg == swfn_pkg::ST_DIV, den_reg != '0,
                      "zero divisor")

endmodule

`default_nettype wire

// File: dv/tb_sliding_window_feature_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_feature_normalizer
// drives feature frames through the normaliser under random flow control and
// checks every result against a fixed-point model of the window statistics
// ----------------------------------------------------------------------------
`default_nettype none

// holds the window statistics and the queue of predicted results
class norm_scoreboard;
    // configuration copy
    int unsigned   feat_cfg;
    int unsigned   ctx_cfg;
    int unsigned   msd_cfg;
    // window state
    longint        frame_vals [swfn_pkg::MAX_FEATURES];
    longint        sum_ring   [swfn_pkg::WINDOW_DEPTH];
    longint        sq_ring    [swfn_pkg::WINDOW_DEPTH];
    longint        win_sum;
    longint        win_sq;
    longint        acc_sum;
    longint        acc_sq;
    int unsigned   head;
    int unsigned   fill;
    int unsigned   pos;
    swfn_pkg::out_item_t pending [$];
    int            errors;

    function new();
        feat_cfg = 1;
        ctx_cfg  = 0;
        msd_cfg  = 0;
        errors   = 0;
        clear_window();
    endfunction

    function void clear_window();
        win_sum = 0;
        win_sq  = 0;
        head    = 0;
        fill    = 0;
        acc_sum = 0;
        acc_sq  = 0;
        pos     = 0;
    endfunction

    function void set_reg(logic [swfn_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
        case (idx)
            swfn_pkg::REG_FEATURE_COUNT: feat_cfg = val & 7'h7f;
            swfn_pkg::REG_LEFT_CONTEXT:  ctx_cfg  = val & 8'hff;
            swfn_pkg::REG_MIN_STDDEV:    msd_cfg  = val & 15'h7fff;
            default: ;
        endcase
    endfunction

    // integer square root, floor
    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // round half away from zero, then saturate to q3.12
    function logic [15:0] round_sat(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q   = (mag * 2 + den) / (den * 2);
        if (num < 0)
            return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    // one accepted input item; predicts the frame's results at its end
    function void note_sample(swfn_pkg::in_item_t it);
        int unsigned     flen;
        int unsigned     cnt;
        int unsigned     slot;
        int unsigned     ctx;
        longint          x;
        longint          n;
        longint unsigned nq;
        longint unsigned s2;
        longint unsigned v;
        longint unsigned r;
        longint unsigned m;
        longint          diff;
        swfn_pkg::out_item_t o;
        if (it.stream_start)
            clear_window();
        flen = feat_cfg;
        if (flen < 1)
            flen = 1;
        if (flen > swfn_pkg::MAX_FEATURES)
            flen = swfn_pkg::MAX_FEATURES;
        x = longint'(it.sample_value);
        pos = pos % swfn_pkg::MAX_FEATURES;
        frame_vals[pos] = x;
        acc_sum += x;
        acc_sq  += x * x;
        if (pos + 1 < flen)
        begin
            pos++;
            return;
        end
        cnt  = pos + 1;
        slot = (head + fill) % swfn_pkg::WINDOW_DEPTH;
        sum_ring[slot] = acc_sum;
        sq_ring[slot]  = acc_sq;
        win_sum += acc_sum;
        win_sq  += acc_sq;
        fill++;
        n  = fill * flen;
        nq = longint'(n) * win_sq;
        m  = (win_sum < 0) ? -win_sum : win_sum;
        s2 = m * m;
        v  = (nq >= s2) ? nq - s2 : 0;
        r  = int_sqrt(v);
        for (int k = 0; k < cnt; k++)
        begin
            diff = n * frame_vals[k] - win_sum;
            if (r > longint'(msd_cfg) * n)
                o.normalized_value = round_sat(diff * 4096, r);
            else
                o.normalized_value = round_sat(diff * 16, n);
            o.feature_position = k[5:0];
            o.frame_last       = (k + 1 == cnt);
            pending.push_back(o);
        end
        ctx = (ctx_cfg > swfn_pkg::WINDOW_DEPTH - 1) ? swfn_pkg::WINDOW_DEPTH - 1 : ctx_cfg;
        if (fill > ctx)
        begin
            win_sum -= sum_ring[head];
            win_sq  -= sq_ring[head];
            head = (head + 1) % swfn_pkg::WINDOW_DEPTH;
            fill--;
        end
        acc_sum = 0;
        acc_sq  = 0;
        pos     = 0;
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_result(swfn_pkg::out_item_t got);
        swfn_pkg::out_item_t want;
        if (pending.size() == 0)
        begin
            report("unexpected result", got.normalized_value, 0);
            return;
        end
        want = pending.pop_front();
        if (got.normalized_value !== want.normalized_value)
            report("normalized_value", got.normalized_value, want.normalized_value);
        if (got.feature_position !== want.feature_position)
            report("feature_position", got.feature_position, want.feature_position);
        if (got.frame_last !== want.frame_last)
            report("frame_last", got.frame_last, want.frame_last);
    endtask
endclass

module tb_sliding_window_feature_normalizer;

    localparam int SETTLE_CYCLES = 2000;
    localparam int CYCLE_LIMIT   = 3000000;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    swfn_pkg::in_item_t                 in_data;
    logic                               out_valid;
    logic                               out_ready;
    swfn_pkg::out_item_t                out_data;
    logic                               cfg_we;
    logic [swfn_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [swfn_pkg::CFG_DATA_BITS-1:0] cfg_data;

    norm_scoreboard sb;
    int             cycles;
    int             sent_in_burst;
    int             burst_len;
    // receiver behaviour: 0 random stalls, 1 always ready, 2 long hold-off
    int             rx_mode;

    sliding_window_feature_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // accepted items and results are observed at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_sample(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // cycle budget for the whole run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: its own stall pattern, with a long hold-off on request
    initial
    begin
        int hold;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_mode == 2)
            begin
                out_ready = 1'b0;
                hold = 0;
                while (hold < 3000)
                begin
                    @(negedge clk);
                    hold++;
                end
                rx_mode = 0;
            end
            else if (rx_mode == 1)
                out_ready = 1'b1;
            else
                out_ready = (($urandom_range(0, 15) & 4'h7) != 0) ||
                            ((cycles / 500) % 3 == 0);
        end
    end

    // registers change only while no frame end is being worked on
    task automatic write_reg(logic [swfn_pkg::CFG_IDX_BITS-1:0] idx, int unsigned val);
        @(negedge clk);
        while (sb.pending.size() != 0 || !in_ready)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[swfn_pkg::CFG_DATA_BITS-1:0];
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // offer one item, holding it until accepted; gaps fall between bursts
    task automatic send_item(logic signed [15:0] val, logic start, bit gaps);
        int gap;
        if (gaps && sent_in_burst >= burst_len)
        begin
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            sent_in_burst = 0;
            burst_len     = $urandom_range(1, 30);
        end
        in_valid = 1'b1;
        in_data.sample_value = val;
        in_data.stream_start = start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        sent_in_burst++;
    endtask

    // wait for every result, then for trailing work to finish
    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample(int spread);
        case (spread)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 511)) - 256);
            default: return 16'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    // runs of feat_cfg items with random content and occasional stream starts
    task automatic send_frames(int frames, int spread);
        for (int f = 0; f < frames; f++)
            for (int k = 0; k < sb.feat_cfg || (sb.feat_cfg == 0 && k < 1); k++)
                send_item(rand_sample(spread), ($urandom_range(0, 40) == 0), 1'b1);
    endtask

    initial
    begin
        int fc;
        int frames;
        sb            = new();
        cycles        = 0;
        rx_mode       = 1;
        sent_in_burst = 0;
        burst_len     = 8;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = swfn_pkg::REG_FEATURE_COUNT;
        cfg_data      = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, extremes, a constant frame and a mid-frame stream start
        send_item(16'sh7fff, 1'b1, 1'b0);
        send_item(16'sh8000, 1'b0, 1'b0);
        write_reg(swfn_pkg::REG_FEATURE_COUNT, 4);
        write_reg(swfn_pkg::REG_LEFT_CONTEXT, 2);
        send_item(16'sh7fff, 1'b0, 1'b0);
        send_item(16'sh8000, 1'b0, 1'b0);
        send_item(16'sh0000, 1'b0, 1'b0);
        send_item(16'shffff, 1'b0, 1'b0);
        repeat (4) send_item(16'sh0100, 1'b0, 1'b0);
        send_item(16'sh0005, 1'b0, 1'b0);
        send_item(16'sh0007, 1'b1, 1'b0);
        repeat (3) send_item(16'sh0001, 1'b0, 1'b0);
        drain();
        // deviation floor at its top makes every deviation count as unit
        write_reg(swfn_pkg::REG_MIN_STDDEV, 32767);
        write_reg(swfn_pkg::REG_FEATURE_COUNT, 0);
        send_item(16'sh1234, 1'b0, 1'b0);
        send_item(16'shedcb, 1'b0, 1'b0);
        drain();
        write_reg(swfn_pkg::REG_MIN_STDDEV, 0);

        // random phases over several settings, extremes included
        rx_mode = 0;
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: fc = 1;
                1: fc = 64;
                2: fc = 127;
                default: fc = $urandom_range(1, 12);
            endcase
            frames = (fc >= 64) ? 1 : (30 / fc + 1);
            write_reg(swfn_pkg::REG_FEATURE_COUNT, fc);
            write_reg(swfn_pkg::REG_LEFT_CONTEXT, (ph == 3) ? 255 : (ph == 4) ? 0 :
                      $urandom_range(0, 6));
            write_reg(swfn_pkg::REG_MIN_STDDEV, (ph == 5) ? $urandom_range(0, 32767) :
                      $urandom_range(0, 40));
            if (ph == 6)
                rx_mode = 2;   // long receiver hold-off while items keep coming
            send_frames(frames, ph % 3);
            if (ph == 2 || ph == 6)
                drain();       // sender pauses until all results are back
        end
        // mid-frame frame-length change, random samples
        write_reg(swfn_pkg::REG_FEATURE_COUNT, 6);
        send_item(rand_sample(1), 1'b0, 1'b0);
        send_item(rand_sample(1), 1'b0, 1'b0);
        send_item(rand_sample(1), 1'b0, 1'b0);
        write_reg(swfn_pkg::REG_FEATURE_COUNT, 2);
        send_item(rand_sample(1), 1'b0, 1'b0);
        for (int i = 0; i < 20; i++)
            send_item(rand_sample(0), 1'b0, 1'b1);

        rx_mode = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+sv
sv/swfn_pkg.sv
sv/sliding_window_feature_normalizer.sv
dv/tb_sliding_window_feature_normalizer.sv
